### src/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`endif

### src/dmcc_pkg.sv
// Shared types, register indexes and depth compare function.
package dmcc_pkg;
	localparam int CoordW = 18;
	localparam int DistW = 17;
	localparam int CountW = 11;
	localparam logic CFG_SPLIT = 1'b0;
	localparam logic CFG_MEMBER = 1'b1;

	typedef logic signed [CoordW-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	function automatic logic depth_near(coord_t a, coord_t b, logic [DistW-1:0] thr);
		logic signed [CoordW:0] d;
		logic [CoordW:0] m;
		d = {a[CoordW-1], a} - {b[CoordW-1], b};
		m = d[CoordW] ? -d : d;
		return m <= {2'b00, thr};
	endfunction
endpackage

### src/dmcc_if.sv
// Point and result channel interfaces.
interface dmcc_pt_if;
	logic valid;
	logic ready;
	logic signed [17:0] point_x;
	logic signed [17:0] point_y;
	logic signed [17:0] point_z;
	logic last_point;
	modport source(output valid, point_x, point_y, point_z, last_point, input ready);
	modport sink(input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface dmcc_res_if;
	logic valid;
	logic ready;
	logic signed [17:0] mean_x;
	logic signed [17:0] mean_y;
	logic signed [17:0] mean_z;
	logic [10:0] member_count;
	modport source(output valid, mean_x, mean_y, mean_z, member_count, input ready);
	modport sink(input valid, mean_x, mean_y, mean_z, member_count, output ready);
endinterface

### src/dmcc_front.sv
// Front end: point store, fill count and one-entry job queue.
module dmcc_front #(
	parameter int MAX_POINTS = 1024,
	parameter int AW = 10,
	parameter int CW = 11
) (
	input logic clk,
	input logic arst_n,
	dmcc_pt_if.sink in_pt,
	input logic [AW-1:0] rd_addr,
	output dmcc_pkg::point_t rd_data,
	output logic job_v,
	output logic [CW-1:0] job_n,
	input logic job_done
);
	import dmcc_pkg::*;

	point_t mem [0:MAX_POINTS-1];
	logic [CW-1:0] cnt_q;
	logic job_v_q;
	logic [CW-1:0] job_n_q;
	logic room;
	logic [CW-1:0] cnt_nx;

	assign in_pt.ready = !job_v_q;
	assign room = cnt_q < CW'(MAX_POINTS);
	assign cnt_nx = room ? cnt_q + 1'b1 : cnt_q;
	assign job_v = job_v_q;
	assign job_n = job_n_q;

	always_ff @(posedge clk) begin
		if (in_pt.valid && in_pt.ready && room) begin
			mem[cnt_q[AW-1:0]] <= '{x: in_pt.point_x, y: in_pt.point_y, z: in_pt.point_z};
		end
		rd_data <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			job_v_q <= 1'b0;
			job_n_q <= '0;
		end else begin
			if (job_done) begin
				job_v_q <= 1'b0;
			end
			if (in_pt.valid && in_pt.ready) begin
				if (in_pt.last_point) begin
					job_v_q <= 1'b1;
					job_n_q <= cnt_nx;
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_nx;
				end
			end
		end
	end
endmodule

### src/dmcc_back.sv
// Back end: class pass, count pass, member sums, divider and result register.
module dmcc_back #(
	parameter int MAX_POINTS = 1024,
	parameter int AW = 10,
	parameter int CW = 11
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_idx,
	input logic [16:0] cfg_wdata,
	output logic [AW-1:0] rd_addr,
	input dmcc_pkg::point_t rd_data,
	input logic job_v,
	input logic [CW-1:0] job_n,
	output logic job_done,
	output logic idle,
	dmcc_res_if.source out_res
);
	import dmcc_pkg::*;

	localparam int SW = CoordW + CW;
	localparam int BW = $clog2(SW + 1);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_INIT = 4'd1;
	localparam logic [3:0] S_INIT2 = 4'd2;
	localparam logic [3:0] S_CL_RDP = 4'd3;
	localparam logic [3:0] S_CL_RDC = 4'd4;
	localparam logic [3:0] S_CL_CMP = 4'd5;
	localparam logic [3:0] S_CT_RDC = 4'd6;
	localparam logic [3:0] S_CT_LAT = 4'd7;
	localparam logic [3:0] S_CT_ACC = 4'd8;
	localparam logic [3:0] S_SUM_ST = 4'd9;
	localparam logic [3:0] S_SUM = 4'd10;
	localparam logic [3:0] S_DIVLD = 4'd11;
	localparam logic [3:0] S_DIV = 4'd12;
	localparam logic [3:0] S_OUT = 4'd13;

	coord_t cmem [0:MAX_POINTS-1];
	coord_t cd_q;
	logic [3:0] st_q;
	logic [16:0] split_q, member_q;
	logic [CW-1:0] i_q, j_q, ncls_q, c_q, best_q, k_q;
	coord_t zi_q, cz_q, bz_q;
	logic signed [SW-1:0] sx_q, sy_q, sz_q;
	logic [1:0] sel_q;
	logic [BW-1:0] bit_q;
	logic [CW-1:0] rem_q;
	logic [SW-1:0] quo_q;
	logic neg_q;
	coord_t rx_q, ry_q, rz_q;
	logic ov_q;
	logic out_go;
	logic [AW-1:0] ca;
	logic cw_en;
	logic [AW-1:0] cw_a;
	coord_t cw_d;
	logic [CW:0] i_nx, j_nx;
	logic hit;
	logic [CW-1:0] c_nx;
	logic signed [SW-1:0] s_sel;
	logic [CW:0] trial;
	logic [SW-1:0] q_fin;
	logic [SW-1:0] q_sgn;

	assign i_nx = {1'b0, i_q} + 1'b1;
	assign j_nx = {1'b0, j_q} + 1'b1;
	assign hit = depth_near(rd_data.z, cz_q, member_q);
	assign c_nx = c_q + CW'(hit);
	assign s_sel = (sel_q == 2'd0) ? sx_q : (sel_q == 2'd1) ? sy_q : sz_q;
	assign trial = {rem_q, quo_q[SW-1]};
	assign q_fin = {quo_q[SW-2:0], trial >= {1'b0, k_q}};
	assign q_sgn = neg_q ? -q_fin : q_fin;
	assign idle = st_q == S_IDLE;
	assign out_go = (st_q == S_OUT) && (!ov_q || out_res.ready);
	assign out_res.valid = ov_q;

	always_comb begin
		rd_addr = '0;
		ca = j_q[AW-1:0];
		cw_en = 1'b0;
		cw_a = ncls_q[AW-1:0];
		cw_d = zi_q;
		unique case (st_q)
			S_CL_RDP: rd_addr = i_q[AW-1:0];
			S_CT_ACC, S_SUM: rd_addr = i_nx[AW-1:0];
			S_CL_CMP: begin
				ca = j_nx[AW-1:0];
				cw_en = !depth_near(zi_q, cd_q, split_q) && !(j_nx < {1'b0, ncls_q})
					&& ncls_q < CW'(MAX_POINTS);
			end
			S_INIT2: begin
				cw_en = 1'b1;
				cw_a = '0;
				cw_d = rd_data.z;
			end
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cw_en) begin
			cmem[cw_a] <= cw_d;
		end
		cd_q <= cmem[ca];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_q <= 17'd320;
			member_q <= 17'd160;
			st_q <= S_IDLE;
			ov_q <= 1'b0;
			job_done <= 1'b0;
		end else begin
			job_done <= out_go;
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_SPLIT: split_q <= cfg_wdata;
					CFG_MEMBER: member_q <= cfg_wdata;
				endcase
			end
			if (out_go) begin
				ov_q <= 1'b1;
			end else if (ov_q && out_res.ready) begin
				ov_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (job_v && !job_done) begin
						st_q <= S_INIT;
					end
				end
				S_INIT: st_q <= S_INIT2;
				S_INIT2: begin
					ncls_q <= CW'(1);
					i_q <= CW'(1);
					j_q <= '0;
					st_q <= (job_n == CW'(1)) ? S_CT_RDC : S_CL_RDP;
				end
				S_CL_RDP: begin
					j_q <= '0;
					st_q <= S_CL_RDC;
				end
				S_CL_RDC: begin
					zi_q <= rd_data.z;
					st_q <= S_CL_CMP;
				end
				S_CL_CMP: begin
					if (!depth_near(zi_q, cd_q, split_q) && j_nx < {1'b0, ncls_q}) begin
						j_q <= j_nx[CW-1:0];
					end else begin
						if (cw_en) begin
							ncls_q <= ncls_q + 1'b1;
						end
						j_q <= '0;
						if (i_nx < {1'b0, job_n}) begin
							i_q <= i_nx[CW-1:0];
							st_q <= S_CL_RDP;
						end else begin
							st_q <= S_CT_RDC;
						end
					end
				end
				S_CT_RDC: st_q <= S_CT_LAT;
				S_CT_LAT: begin
					cz_q <= cd_q;
					c_q <= '0;
					i_q <= '0;
					st_q <= S_CT_ACC;
				end
				S_CT_ACC: begin
					if (i_nx < {1'b0, job_n}) begin
						i_q <= i_nx[CW-1:0];
						c_q <= c_nx;
					end else begin
						if (j_q == '0 || c_nx > best_q) begin
							best_q <= c_nx;
							bz_q <= cz_q;
						end
						if (j_nx < {1'b0, ncls_q}) begin
							j_q <= j_nx[CW-1:0];
							st_q <= S_CT_RDC;
						end else begin
							st_q <= S_SUM_ST;
						end
					end
				end
				S_SUM_ST: begin
					cz_q <= bz_q;
					i_q <= '0;
					sx_q <= '0;
					sy_q <= '0;
					sz_q <= '0;
					c_q <= '0;
					st_q <= S_SUM;
				end
				S_SUM: begin
					if (hit) begin
						sx_q <= sx_q + SW'(rd_data.x);
						sy_q <= sy_q + SW'(rd_data.y);
						sz_q <= sz_q + SW'(rd_data.z);
					end
					c_q <= c_nx;
					i_q <= i_nx[CW-1:0];
					if (!(i_nx < {1'b0, job_n})) begin
						k_q <= c_nx;
						sel_q <= '0;
						st_q <= S_DIVLD;
					end
				end
				S_DIVLD: begin
					neg_q <= s_sel[SW-1];
					quo_q <= s_sel[SW-1] ? -s_sel : s_sel;
					rem_q <= '0;
					bit_q <= '0;
					st_q <= S_DIV;
				end
				S_DIV: begin
					quo_q <= q_fin;
					rem_q <= (trial >= {1'b0, k_q}) ? CW'(trial - {1'b0, k_q})
						: trial[CW-1:0];
					bit_q <= bit_q + 1'b1;
					if (bit_q == BW'(SW - 1)) begin
						sel_q <= sel_q + 1'b1;
						unique case (sel_q)
							2'd0: rx_q <= q_sgn[CoordW-1:0];
							2'd1: ry_q <= q_sgn[CoordW-1:0];
							default: rz_q <= q_sgn[CoordW-1:0];
						endcase
						st_q <= (sel_q == 2'd2) ? S_OUT : S_DIVLD;
					end
				end
				S_OUT: begin
					if (out_go) begin
						out_res.mean_x <= rx_q;
						out_res.mean_y <= ry_q;
						out_res.mean_z <= rz_q;
						out_res.member_count <= CountW'(k_q);
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

### src/depth_mode_cluster_centroid.sv
// Top level: depth-mode cluster centroid over a loaded point set.
//
//  channel   | dir | beat
//  in_pt     | in  | one point, last_point closes the set
//  out_res   | out | means and member count of the winning class
//  cfg_*     | in  | register write, no handshake
//
// Points load at one beat per cycle into the point store while in_pt.ready is high.
// After the last point, the sequencer runs class forming, then counting, then member sums,
// then the shared divider once for each of the three means.
// Input is held off from the last point until job_done, registered after the result enters
// the output register, clears the job flag.
// The output register lets the next set load while a result waits to be taken.
`include "assert_macros.svh"
module depth_mode_cluster_centroid #(
	parameter int MAX_POINTS = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_idx,
	input logic [16:0] cfg_wdata,
	dmcc_pt_if.sink in_pt,
	dmcc_res_if.source out_res
);
	import dmcc_pkg::*;

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

	logic [AW-1:0] rd_addr;
	point_t rd_data;
	logic job_v, job_done, bk_idle;
	logic [CW-1:0] job_n;

	dmcc_front #(.MAX_POINTS(MAX_POINTS), .AW(AW), .CW(CW)) u_front (
		.clk(clk), .arst_n(arst_n), .in_pt(in_pt), .rd_addr(rd_addr), .rd_data(rd_data),
		.job_v(job_v), .job_n(job_n), .job_done(job_done)
	);

	dmcc_back #(.MAX_POINTS(MAX_POINTS), .AW(AW), .CW(CW)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .rd_addr(rd_addr), .rd_data(rd_data), .job_v(job_v),
		.job_n(job_n), .job_done(job_done), .idle(bk_idle), .out_res(out_res)
	);

	`ASSERT_IMP(a_idle_no_job, clk, arst_n, !job_v, bk_idle)
	`ASSERT_IMP(a_rise_in_job, clk, arst_n, $rose(out_res.valid), $past(job_v))
	`ASSERT_NXT(a_done_frees, clk, arst_n, job_done, in_pt.ready)
endmodule
